### rtl/srt_pkg.sv
// Shared types and constants of the sparse row transpose block.
// Holds command and status codes, field widths, state types and parameter defaults.
// No dependencies.
package srt_pkg;

   localparam int MAX_SLOTS_DEFAULT   = 1024;
   localparam int MAX_ENTRIES_DEFAULT = 4096;
   localparam int VALUE_BITS_DEFAULT  = 64;

   localparam int COMMAND_W    = 2;
   localparam int ROW_W        = 10;
   localparam int COLUMN_W     = 16;
   localparam int VALUE_W      = 64;
   localparam int OUT_COLUMN_W = 10;
   localparam int KEPT_W       = 13;
   localparam int STATUS_W     = 2;
   localparam int SLOT_COUNT_W = 11;
   localparam int CMP_W        = 17;

   localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RESET = 11'd1024;

   localparam logic [COMMAND_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [COMMAND_W-1:0] CMD_FINISH = 2'd1;
   localparam logic [COMMAND_W-1:0] CMD_FETCH  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_PHASE = 2'd3;

   typedef enum logic {
      PHASE_LOADING,
      PHASE_FETCHING
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_COUNT_RD,
      ST_COUNT_COL,
      ST_COUNT_WR,
      ST_SCAN_RD,
      ST_SCAN_WR,
      ST_SCATTER_RD,
      ST_SCATTER_COL,
      ST_SCATTER_WR,
      ST_REPORT
   } state_type;

endpackage

### rtl/sparse_row_transpose.sv
// Sparse row transpose: stable counting-sort transpose of loaded (row, column, value) entries.
// Depends on srt_pkg for codes, widths, state types and parameter defaults.
//
// Load and fetch transactions keep busy low and their result strobe follows in the cycle
// after start, so they may be issued back to back. A finish transaction holds busy
// through the sort pass, which runs on the column memory and the two entry memories, one
// read-modify-write at a time: it clears max(S,1) column counts, counts the stored entries
// per column (skipping an entry whose column is at or above S), turns max(S,1) counts into
// prefix sums, scatters the stored entries the same way and reports, after which the
// result strobe follows, where S is the effective slot count. The result strobe cannot be
// held off; every transaction yields exactly one result, one cycle wide.
module sparse_row_transpose #(
   parameter int MAX_SLOTS   = srt_pkg::MAX_SLOTS_DEFAULT,
   parameter int MAX_ENTRIES = srt_pkg::MAX_ENTRIES_DEFAULT,
   parameter int VALUE_BITS  = srt_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [srt_pkg::COMMAND_W-1:0]      req_command,
   input  logic [srt_pkg::ROW_W-1:0]          req_row,
   input  logic [srt_pkg::COLUMN_W-1:0]       req_column,
   input  logic [srt_pkg::VALUE_W-1:0]        req_value,
   output logic                               rsp_valid,
   output logic [srt_pkg::ROW_W-1:0]          rsp_out_row,
   output logic [srt_pkg::OUT_COLUMN_W-1:0]   rsp_out_column,
   output logic [srt_pkg::VALUE_W-1:0]        rsp_out_value,
   output logic                               rsp_last,
   output logic [srt_pkg::KEPT_W-1:0]         rsp_kept_count,
   output logic [srt_pkg::STATUS_W-1:0]       rsp_status,
   input  logic                               csr_write_enable,
   input  logic [srt_pkg::SLOT_COUNT_W-1:0]   csr_write_data
);

   localparam int SLOT_W       = $clog2(MAX_SLOTS);
   localparam int ENTRY_W      = $clog2(MAX_ENTRIES);
   localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W        = srt_pkg::CMP_W;
   localparam int ROW_W        = srt_pkg::ROW_W;
   localparam int KEPT_W       = srt_pkg::KEPT_W;
   localparam int OUT_COLUMN_W = srt_pkg::OUT_COLUMN_W;
   localparam int VALUE_W      = srt_pkg::VALUE_W;

   logic [CNT_W-1:0]      col_mem       [MAX_SLOTS];
   logic [ROW_W-1:0]      ld_row_mem    [MAX_ENTRIES];
   logic [SLOT_W-1:0]     ld_col_mem    [MAX_ENTRIES];
   logic [VALUE_BITS-1:0] ld_val_mem    [MAX_ENTRIES];
   logic [ROW_W-1:0]      so_row_mem    [MAX_ENTRIES];
   logic [SLOT_W-1:0]     so_col_mem    [MAX_ENTRIES];
   logic [VALUE_BITS-1:0] so_val_mem    [MAX_ENTRIES];

   logic [CNT_W-1:0]      col_rd_ff;
   logic [ROW_W-1:0]      ld_row_rd_ff;
   logic [SLOT_W-1:0]     ld_col_rd_ff;
   logic [VALUE_BITS-1:0] ld_val_rd_ff;
   logic [ROW_W-1:0]      so_row_rd_ff;
   logic [SLOT_W-1:0]     so_col_rd_ff;
   logic [VALUE_BITS-1:0] so_val_rd_ff;

   logic                  col_we, col_re;
   logic [SLOT_W-1:0]     col_waddr, col_raddr;
   logic [CNT_W-1:0]      col_wdata;
   logic                  ld_we, ld_re;
   logic [ENTRY_W-1:0]    ld_waddr, ld_raddr;
   logic                  so_we, so_re;
   logic [ENTRY_W-1:0]    so_waddr, so_raddr;

   srt_pkg::state_type    state_ff, state_in;
   srt_pkg::phase_type    phase_ff, phase_in;
   logic [srt_pkg::SLOT_COUNT_W-1:0] slot_count_ff;
   logic [CNT_W-1:0]      entry_total_ff, entry_total_in;
   logic [CNT_W-1:0]      fetch_ptr_ff, fetch_ptr_in;
   logic [CNT_W-1:0]      entry_idx_ff, entry_idx_in;
   logic [SLOT_W:0]       slot_idx_ff, slot_idx_in;
   logic [CNT_W-1:0]      kept_ff, kept_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [KEPT_W-1:0]     rsp_kept_ff, rsp_kept_in;
   logic [srt_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [CMP_W-1:0]      slot_count_ext, eff_slots;
   logic                  req_in_range, ld_in_range;
   logic [CNT_W-1:0]      entry_next, fetch_next;
   logic                  entry_done;
   logic [SLOT_W:0]       slot_next;
   logic                  slot_done;

   assign slot_count_ext = CMP_W'(slot_count_ff);
   assign eff_slots      = (slot_count_ext < CMP_W'(MAX_SLOTS)) ? slot_count_ext
                                                                : CMP_W'(MAX_SLOTS);
   assign req_in_range   = CMP_W'(req_column) < eff_slots;
   assign ld_in_range    = CMP_W'(ld_col_rd_ff) < eff_slots;
   assign entry_next     = entry_idx_ff + 1'b1;
   assign entry_done     = entry_next >= entry_total_ff;
   assign fetch_next     = fetch_ptr_ff + 1'b1;
   assign slot_next      = slot_idx_ff + 1'b1;
   assign slot_done      = CMP_W'(slot_next) >= eff_slots;

   always_ff @(posedge clock) begin
      if (col_we) begin
         col_mem[col_waddr] <= col_wdata;
      end
      if (col_re) begin
         col_rd_ff <= col_mem[col_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ld_we) begin
         ld_row_mem[ld_waddr] <= req_row;
         ld_col_mem[ld_waddr] <= req_column[SLOT_W-1:0];
         ld_val_mem[ld_waddr] <= req_value[VALUE_BITS-1:0];
      end
      if (ld_re) begin
         ld_row_rd_ff <= ld_row_mem[ld_raddr];
         ld_col_rd_ff <= ld_col_mem[ld_raddr];
         ld_val_rd_ff <= ld_val_mem[ld_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (so_we) begin
         so_row_mem[so_waddr] <= ld_row_rd_ff;
         so_col_mem[so_waddr] <= ld_col_rd_ff;
         so_val_mem[so_waddr] <= ld_val_rd_ff;
      end
      if (so_re) begin
         so_row_rd_ff <= so_row_mem[so_raddr];
         so_col_rd_ff <= so_col_mem[so_raddr];
         so_val_rd_ff <= so_val_mem[so_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= srt_pkg::ST_IDLE;
         phase_ff       <= srt_pkg::PHASE_LOADING;
         slot_count_ff  <= srt_pkg::SLOT_COUNT_RESET;
         entry_total_ff <= '0;
         fetch_ptr_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         entry_total_ff <= entry_total_in;
         fetch_ptr_ff   <= fetch_ptr_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_write_enable) begin
            slot_count_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_idx_ff  <= entry_idx_in;
      slot_idx_ff   <= slot_idx_in;
      kept_ff       <= kept_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_kept_ff   <= rsp_kept_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      entry_total_in = entry_total_ff;
      fetch_ptr_in   = fetch_ptr_ff;
      entry_idx_in   = entry_idx_ff;
      slot_idx_in    = slot_idx_ff;
      kept_in        = kept_ff;
      rsp_valid_in   = 1'b0;
      rsp_hit_in     = rsp_hit_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_kept_in    = rsp_kept_ff;
      rsp_status_in  = rsp_status_ff;
      col_we         = 1'b0;
      col_re         = 1'b0;
      col_waddr      = slot_idx_ff[SLOT_W-1:0];
      col_raddr      = slot_idx_ff[SLOT_W-1:0];
      col_wdata      = '0;
      ld_we          = 1'b0;
      ld_re          = 1'b0;
      ld_waddr       = entry_total_ff[ENTRY_W-1:0];
      ld_raddr       = entry_idx_ff[ENTRY_W-1:0];
      so_we          = 1'b0;
      so_re          = 1'b0;
      so_waddr       = col_rd_ff[ENTRY_W-1:0];
      so_raddr       = fetch_ptr_ff[ENTRY_W-1:0];

      case (state_ff)
         srt_pkg::ST_IDLE: begin
            if (start) begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = 1'b0;
               rsp_last_in   = 1'b0;
               rsp_kept_in   = '0;
               rsp_status_in = srt_pkg::STATUS_OK;
               case (req_command)
                  srt_pkg::CMD_LOAD: begin
                     if (phase_ff != srt_pkg::PHASE_LOADING) begin
                        rsp_status_in = srt_pkg::STATUS_PHASE;
                     end else if (req_in_range) begin
                        if (entry_total_ff >= CNT_W'(MAX_ENTRIES)) begin
                           rsp_status_in = srt_pkg::STATUS_FULL;
                        end else begin
                           ld_we          = 1'b1;
                           entry_total_in = entry_total_ff + 1'b1;
                        end
                     end
                  end
                  srt_pkg::CMD_FINISH: begin
                     if (phase_ff != srt_pkg::PHASE_LOADING) begin
                        rsp_status_in = srt_pkg::STATUS_PHASE;
                     end else begin
                        rsp_valid_in = 1'b0;
                        slot_idx_in  = '0;
                        kept_in      = '0;
                        state_in     = srt_pkg::ST_CLEAR;
                     end
                  end
                  srt_pkg::CMD_FETCH: begin
                     if (phase_ff != srt_pkg::PHASE_FETCHING) begin
                        rsp_status_in = srt_pkg::STATUS_PHASE;
                     end else begin
                        rsp_kept_in = KEPT_W'(entry_total_ff);
                        if (fetch_ptr_ff >= entry_total_ff) begin
                           rsp_status_in  = srt_pkg::STATUS_EMPTY;
                           entry_total_in = '0;
                           fetch_ptr_in   = '0;
                           phase_in       = srt_pkg::PHASE_LOADING;
                        end else begin
                           so_re        = 1'b1;
                           rsp_hit_in   = 1'b1;
                           fetch_ptr_in = fetch_next;
                           if (fetch_next >= entry_total_ff) begin
                              rsp_last_in    = 1'b1;
                              entry_total_in = '0;
                              fetch_ptr_in   = '0;
                              phase_in       = srt_pkg::PHASE_LOADING;
                           end
                        end
                     end
                  end
                  default: begin
                     rsp_status_in = srt_pkg::STATUS_PHASE;
                  end
               endcase
            end
         end
         srt_pkg::ST_CLEAR: begin
            col_we      = 1'b1;
            col_wdata   = '0;
            slot_idx_in = slot_next;
            if (slot_done) begin
               slot_idx_in  = '0;
               entry_idx_in = '0;
               state_in     = (entry_total_ff == '0) ? srt_pkg::ST_SCAN_RD
                                                     : srt_pkg::ST_COUNT_RD;
            end
         end
         srt_pkg::ST_COUNT_RD: begin
            ld_re    = 1'b1;
            state_in = srt_pkg::ST_COUNT_COL;
         end
         srt_pkg::ST_COUNT_COL: begin
            if (ld_in_range) begin
               col_re    = 1'b1;
               col_raddr = ld_col_rd_ff;
               state_in  = srt_pkg::ST_COUNT_WR;
            end else begin
               entry_idx_in = entry_next;
               slot_idx_in  = '0;
               state_in     = entry_done ? srt_pkg::ST_SCAN_RD : srt_pkg::ST_COUNT_RD;
            end
         end
         srt_pkg::ST_COUNT_WR: begin
            col_we       = 1'b1;
            col_waddr    = ld_col_rd_ff;
            col_wdata    = col_rd_ff + 1'b1;
            entry_idx_in = entry_next;
            slot_idx_in  = '0;
            state_in     = entry_done ? srt_pkg::ST_SCAN_RD : srt_pkg::ST_COUNT_RD;
         end
         srt_pkg::ST_SCAN_RD: begin
            col_re   = 1'b1;
            state_in = srt_pkg::ST_SCAN_WR;
         end
         srt_pkg::ST_SCAN_WR: begin
            col_we      = 1'b1;
            col_wdata   = kept_ff;
            kept_in     = kept_ff + col_rd_ff;
            slot_idx_in = slot_next;
            state_in    = srt_pkg::ST_SCAN_RD;
            if (slot_done) begin
               entry_idx_in = '0;
               state_in     = (entry_total_ff == '0) ? srt_pkg::ST_REPORT
                                                     : srt_pkg::ST_SCATTER_RD;
            end
         end
         srt_pkg::ST_SCATTER_RD: begin
            ld_re    = 1'b1;
            state_in = srt_pkg::ST_SCATTER_COL;
         end
         srt_pkg::ST_SCATTER_COL: begin
            if (ld_in_range) begin
               col_re    = 1'b1;
               col_raddr = ld_col_rd_ff;
               state_in  = srt_pkg::ST_SCATTER_WR;
            end else begin
               entry_idx_in = entry_next;
               state_in     = entry_done ? srt_pkg::ST_REPORT : srt_pkg::ST_SCATTER_RD;
            end
         end
         srt_pkg::ST_SCATTER_WR: begin
            so_we        = 1'b1;
            col_we       = 1'b1;
            col_waddr    = ld_col_rd_ff;
            col_wdata    = col_rd_ff + 1'b1;
            entry_idx_in = entry_next;
            state_in     = entry_done ? srt_pkg::ST_REPORT : srt_pkg::ST_SCATTER_RD;
         end
         srt_pkg::ST_REPORT: begin
            rsp_valid_in   = 1'b1;
            rsp_hit_in     = 1'b0;
            rsp_last_in    = 1'b0;
            rsp_kept_in    = KEPT_W'(kept_ff);
            rsp_status_in  = srt_pkg::STATUS_OK;
            entry_total_in = kept_ff;
            fetch_ptr_in   = '0;
            phase_in       = srt_pkg::PHASE_FETCHING;
            state_in       = srt_pkg::ST_IDLE;
         end
         default: begin
            state_in = srt_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy           = state_ff != srt_pkg::ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_row    = rsp_hit_ff ? so_row_rd_ff : '0;
   assign rsp_out_column = rsp_hit_ff ? OUT_COLUMN_W'(so_col_rd_ff) : '0;
   assign rsp_out_value  = rsp_hit_ff ? VALUE_W'(so_val_rd_ff) : '0;
   assign rsp_last       = rsp_last_ff;
   assign rsp_kept_count = rsp_kept_ff;
   assign rsp_status     = rsp_status_ff;

   a_quick_response : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !(req_command == srt_pkg::CMD_FINISH &&
                           phase_ff == srt_pkg::PHASE_LOADING)) |=> rsp_valid)
      else $error("accepted transaction gave no result in the next cycle");

   a_fetch_bound : assert property (@(posedge clock) disable iff (reset)
      fetch_ptr_ff <= entry_total_ff)
      else $error("fetch pointer passed the entry total");

   a_entry_bound : assert property (@(posedge clock) disable iff (reset)
      entry_total_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry total exceeds the store depth");

   a_last_drains : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |->
         (phase_ff == srt_pkg::PHASE_LOADING && entry_total_ff == '0))
      else $error("final fetched entry did not return the block to loading");

endmodule
